@@ rtl/core/mbps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the multi-bus poll sequencer.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam logic [15:0] FLAG_BAD_BUS    = 16'hF0F0;
	localparam logic [15:0] FLAG_QUEUE_FULL = 16'hF1F1;
	localparam logic [3:0]  TICK_MAX        = 4'd15;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_ADD   = 2'd1,
		OP_VISIT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_SEND  = 2'd1,
		ACT_STORE = 2'd2
	} act_t;

	typedef enum logic [0:0] {
		ST_IDLE  = 1'b0,
		ST_FETCH = 1'b1
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  motor_index;
		logic [7:0]  bus_number;
		logic [7:0]  servo_id;
		logic [2:0]  bus_slot;
		logic        reply_ready;
		logic [15:0] reply_position;
	} item_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
		logic load_direct;
		logic load_fetch;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_fetch;
		logic out_valid;
	} dp_status_t;

endpackage

@@ rtl/core/mbps_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_if
// Valid/ready channels carrying poll sequencer items and results.
// ----------------------------------------------------------------------------
interface mbps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  motor_index;
	logic [7:0]  bus_number;
	logic [7:0]  servo_id;
	logic [2:0]  bus_slot;
	logic        reply_ready;
	logic [15:0] reply_position;

	modport source (
		output valid, operation, motor_index, bus_number, servo_id, bus_slot,
		       reply_ready, reply_position,
		input  ready
	);
	modport sink (
		input  valid, operation, motor_index, bus_number, servo_id, bus_slot,
		       reply_ready, reply_position,
		output ready
	);
endinterface

interface mbps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [2:0]  action_bus;
	logic [7:0]  request_servo;
	logic [7:0]  result_slot;
	logic [15:0] result_value;
	logic        collection_done;

	modport source (
		output valid, action, action_bus, request_servo, result_slot, result_value,
		       collection_done,
		input  ready
	);
	modport sink (
		input  valid, action, action_bus, request_servo, result_slot, result_value,
		       collection_done,
		output ready
	);
endinterface

@@ rtl/core/mbps_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/mbps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_ctrl
// Sequencer control: accepts a transaction, waits on the queue read if needed.
// ----------------------------------------------------------------------------
module mbps_ctrl
	import mbps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output logic       in_ready,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   accept;

	// output slot is free or drains at this edge
	assign in_ready = (state_q == ST_IDLE) && (!status.out_valid || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && status.needs_fetch) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.exec        = accept;
				cmd.load_direct = accept && !status.needs_fetch;
			end
			ST_FETCH: begin
				cmd.load_fetch = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/mbps_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_dp
// Sequencer datapath: per-bus queue counters, queue memory, result register.
// ----------------------------------------------------------------------------
module mbps_dp
	import mbps_pkg::*;
#(
	parameter int BUS_COUNT      = 8,
	parameter int MOTORS_PER_BUS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  item_t       itm,
	input  ctrl_cmd_t   cmd,
	input  logic        out_ready,
	output dp_status_t  status,
	output logic        out_valid,
	output logic [1:0]  action,
	output logic [2:0]  action_bus,
	output logic [7:0]  request_servo,
	output logic [7:0]  result_slot,
	output logic [15:0] result_value,
	output logic        collection_done
);

	localparam int DEPTH = BUS_COUNT * MOTORS_PER_BUS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
	localparam int CW    = $clog2(MOTORS_PER_BUS + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MOTORS_PER_BUS);

	logic [7:0]    enable_q;
	logic [CW-1:0] cnt_q  [BUS_COUNT];
	logic [CW-1:0] send_q [BUS_COUNT];
	logic [CW-1:0] coll_q [BUS_COUNT];
	logic [BUS_COUNT-1:0] wait_q;
	logic          done_q;
	logic [3:0]    tick_q;

	logic [CW-1:0] cnt_d  [BUS_COUNT];
	logic [CW-1:0] send_d [BUS_COUNT];
	logic [CW-1:0] coll_d [BUS_COUNT];
	logic [BUS_COUNT-1:0] wait_d;
	logic          done_d;
	logic [3:0]    tick_d;

	logic [BUS_COUNT-1:0] nonempty;
	logic [3:0]    active;

	// pending result of a transaction waiting on the queue read
	act_t          pend_action_q;
	logic [2:0]    pend_bus_q;
	logic [15:0]   pend_value_q;

	act_t          dir_action;
	logic [7:0]    dir_slot;
	logic [15:0]   dir_value;
	logic          fetch;
	act_t          fetch_action;

	logic          add_wr;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	logic [7:0]    add_bus8;
	logic [BW-1:0] add_bi;
	logic [BW-1:0] vis_si;
	logic          vis_ok;
	logic [3:0]    tick_base;

	always_comb begin
		for (int b = 0; b < BUS_COUNT; b++) begin
			nonempty[b] = (cnt_q[b] != '0);
		end
		active = 4'($countones(nonempty));
	end

	assign add_bus8 = itm.bus_number - 8'd1;
	assign add_bi   = add_bus8[BW-1:0];
	assign vis_si   = itm.bus_slot[BW-1:0];
	assign vis_ok   = ({1'b0, itm.bus_slot} < 4'(BUS_COUNT)) && !done_q;
	assign ram_we   = add_wr && cmd.exec;

	always_comb begin
		cnt_d        = cnt_q;
		send_d       = send_q;
		coll_d       = coll_q;
		wait_d       = wait_q;
		done_d       = done_q;
		tick_d       = tick_q;
		dir_action   = ACT_NONE;
		dir_slot     = '0;
		dir_value    = '0;
		fetch        = 1'b0;
		fetch_action = ACT_NONE;
		add_wr       = 1'b0;
		ram_waddr    = '0;
		ram_wdata    = {itm.motor_index, itm.servo_id};
		ram_raddr    = '0;
		tick_base    = tick_q;
		unique case (op_t'(itm.operation))
			OP_BEGIN: begin
				for (int b = 0; b < BUS_COUNT; b++) begin
					cnt_d[b]  = '0;
					send_d[b] = '0;
					coll_d[b] = '0;
				end
				wait_d = '0;
				done_d = 1'b0;
			end
			OP_ADD: begin
				if (add_bus8 >= 8'(BUS_COUNT) || !enable_q[add_bus8[2:0]]) begin
					dir_action = ACT_STORE;
					dir_slot   = itm.motor_index;
					dir_value  = FLAG_BAD_BUS;
				end else if (cnt_q[add_bi] >= CNT_FULL) begin
					dir_action = ACT_STORE;
					dir_slot   = itm.motor_index;
					dir_value  = FLAG_QUEUE_FULL;
				end else begin
					add_wr    = 1'b1;
					ram_waddr = AW'(int'(add_bi) * MOTORS_PER_BUS + int'(cnt_q[add_bi]));
					cnt_d[add_bi] = cnt_q[add_bi] + CW'(1);
				end
			end
			OP_VISIT: begin
				if (vis_ok) begin
					if (itm.bus_slot == 3'd0) begin
						tick_base = '0;
					end
					tick_d = tick_base;
					if (coll_q[vis_si] >= cnt_q[vis_si]) begin
						if (cnt_q[vis_si] != '0 && tick_base < TICK_MAX) begin
							tick_d = tick_base + 4'd1;
						end
					end else if (wait_q[vis_si]) begin
						if (itm.reply_ready) begin
							fetch        = 1'b1;
							fetch_action = ACT_STORE;
							ram_raddr    = AW'(int'(vis_si) * MOTORS_PER_BUS
							               + int'(coll_q[vis_si]));
							coll_d[vis_si] = coll_q[vis_si] + CW'(1);
							wait_d[vis_si] = 1'b0;
						end
					end else if (send_q[vis_si] < cnt_q[vis_si]) begin
						fetch        = 1'b1;
						fetch_action = ACT_SEND;
						ram_raddr    = AW'(int'(vis_si) * MOTORS_PER_BUS
						               + int'(send_q[vis_si]));
						send_d[vis_si] = send_q[vis_si] + CW'(1);
						wait_d[vis_si] = 1'b1;
					end
					// last slot of the tick closes the round once the tick has counted every active bus as finished
					if ({1'b0, itm.bus_slot} == 4'(BUS_COUNT - 1) && tick_d >= active) begin
						done_d = 1'b1;
					end
				end
			end
			default: begin
				dir_action = ACT_NONE;
			end
		endcase
	end

	assign status.needs_fetch = fetch;
	assign status.out_valid   = out_valid;

	mbps_ram #(
		.WIDTH (16),
		.DEPTH (DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUS_COUNT; b++) begin
				cnt_q[b]  <= '0;
				send_q[b] <= '0;
				coll_q[b] <= '0;
			end
			wait_q <= '0;
			done_q <= 1'b0;
			tick_q <= '0;
		end else if (cmd.exec) begin
			cnt_q  <= cnt_d;
			send_q <= send_d;
			coll_q <= coll_d;
			wait_q <= wait_d;
			done_q <= done_d;
			tick_q <= tick_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pend_action_q <= fetch_action;
			pend_bus_q    <= itm.bus_slot;
			pend_value_q  <= itm.reply_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_direct || cmd.load_fetch) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_direct) begin
			action          <= dir_action;
			action_bus      <= '0;
			request_servo   <= '0;
			result_slot     <= dir_slot;
			result_value    <= dir_value;
			collection_done <= done_d;
		end else if (cmd.load_fetch) begin
			action          <= pend_action_q;
			collection_done <= done_q;
			if (pend_action_q == ACT_SEND) begin
				action_bus    <= pend_bus_q;
				request_servo <= ram_rdata[7:0];
				result_slot   <= '0;
				result_value  <= '0;
			end else begin
				action_bus    <= '0;
				request_servo <= '0;
				result_slot   <= ram_rdata[15:8];
				result_value  <= pend_value_q;
			end
		end
	end

endmodule

@@ rtl/core/multi_bus_poll_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_bus_poll_sequencer_core
// Schedules position polls over several half-duplex buses, one request in
// flight per bus, and reports sends, stored results and collection done.
// ----------------------------------------------------------------------------
// usage:
//   item   valid/ready channel of begin, add-motor and visit transactions
//   result valid/ready channel, exactly one result transaction per item
//   cfg_we/cfg_wdata write the bus enable mask, only while the block is idle
// result path:
//   begin, add and visits that do nothing: result registered in the cycle after
//   accept, one item per cycle while the result side is not stalled
//   visits that send a request or store a reply: result loaded in the fetch
//   state from the registered read port of the queue memory holding slot index
//   and servo id; no new item is taken until that result is loaded
// reset clears the enable mask, every per-bus counter and the done flag; the
// queue memory needs no clearing since entries are only read below the count
// a stalled result holds in the output register; a new item is taken in the
// cycle the held result drains
// ----------------------------------------------------------------------------
module multi_bus_poll_sequencer_core
	import mbps_pkg::*;
#(
	parameter int BUS_COUNT      = 8,
	parameter int MOTORS_PER_BUS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	mbps_in_if.sink     item,
	mbps_out_if.source  result
);

	item_t      itm;
	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       in_ready;

	assign itm = '{
		operation:      item.operation,
		motor_index:    item.motor_index,
		bus_number:     item.bus_number,
		servo_id:       item.servo_id,
		bus_slot:       item.bus_slot,
		reply_ready:    item.reply_ready,
		reply_position: item.reply_position
	};

	assign item.ready = in_ready;

	mbps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.out_ready (result.ready),
		.status    (status),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	mbps_dp #(
		.BUS_COUNT      (BUS_COUNT),
		.MOTORS_PER_BUS (MOTORS_PER_BUS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.itm             (itm),
		.cmd             (cmd),
		.out_ready       (result.ready),
		.status          (status),
		.out_valid       (result.valid),
		.action          (result.action),
		.action_bus      (result.action_bus),
		.request_servo   (result.request_servo),
		.result_slot     (result.result_slot),
		.result_value    (result.result_value),
		.collection_done (result.collection_done)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multi_bus_poll_sequencer_core: drives begin, add and
// visit transactions with random idling and back-pressure. A scoreboard keeps
// its own copy of the bus queues and predicts every result transaction.
// ----------------------------------------------------------------------------
module tb;
	import mbps_pkg::*;

	localparam int BUSES      = 8;
	localparam int DEPTH      = 8;
	localparam int ITEM_GOAL  = 850;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		act_t        action;
		logic [2:0]  bus;
		logic [7:0]  servo;
		logic [7:0]  slot;
		logic [15:0] value;
		logic        done;
	} poll_result_t;

	class poll_scoreboard;
		logic [7:0]   enable_mask;
		logic [7:0]   slot_store [0:BUSES*DEPTH-1];
		logic [7:0]   servo_store [0:BUSES*DEPTH-1];
		logic [3:0]   count [0:BUSES-1];
		logic [3:0]   send_ptr [0:BUSES-1];
		logic [3:0]   collect_ptr [0:BUSES-1];
		bit           awaiting [0:BUSES-1];
		bit           done;
		logic [3:0]   tick_done;
		poll_result_t pending_actions [$];
		int           mismatches;

		function new();
			enable_mask = '0;
			clear_queues();
			done = 0;
			tick_done = '0;
			mismatches = 0;
		endfunction

		function void clear_queues();
			for (int b = 0; b < BUSES; b++) begin
				count[b] = '0;
				send_ptr[b] = '0;
				collect_ptr[b] = '0;
				awaiting[b] = 0;
			end
		endfunction

		function void write_enable(logic [7:0] mask);
			enable_mask = mask;
		endfunction

		function int outstanding();
			return pending_actions.size();
		endfunction

		// work out the result of one accepted item and queue it
		function void note_item(item_t it);
			poll_result_t r;
			logic [7:0] b;
			int s;
			int e;
			int active;
			r = '0;
			r.action = ACT_NONE;
			case (it.operation)
				OP_BEGIN: begin
					clear_queues();
					done = 0;
				end
				OP_ADD: begin
					b = it.bus_number - 8'd1;
					if (b >= BUSES || !enable_mask[b[2:0]]) begin
						r.action = ACT_STORE;
						r.slot = it.motor_index;
						r.value = FLAG_BAD_BUS;
					end else if (count[b] >= DEPTH) begin
						r.action = ACT_STORE;
						r.slot = it.motor_index;
						r.value = FLAG_QUEUE_FULL;
					end else begin
						e = b * DEPTH + count[b];
						slot_store[e] = it.motor_index;
						servo_store[e] = it.servo_id;
						count[b] = count[b] + 4'd1;
					end
				end
				OP_VISIT: begin
					s = it.bus_slot;
					if (!done && s < BUSES) begin
						if (s == 0)
							tick_done = '0;
						if (collect_ptr[s] >= count[s]) begin
							if (count[s] > 0 && tick_done < TICK_MAX)
								tick_done = tick_done + 4'd1;
						end else if (awaiting[s]) begin
							if (it.reply_ready) begin
								r.action = ACT_STORE;
								r.slot = slot_store[s * DEPTH + collect_ptr[s]];
								r.value = it.reply_position;
								collect_ptr[s] = collect_ptr[s] + 4'd1;
								awaiting[s] = 0;
							end
						end else if (send_ptr[s] < count[s]) begin
							r.action = ACT_SEND;
							r.bus = 3'(s);
							r.servo = servo_store[s * DEPTH + send_ptr[s]];
							send_ptr[s] = send_ptr[s] + 4'd1;
							awaiting[s] = 1;
						end
						// done check at the last slot of the tick
						if (s == BUSES - 1) begin
							active = 0;
							for (int k = 0; k < BUSES; k++)
								if (count[k] > 0)
									active++;
							if (tick_done >= active)
								done = 1;
						end
					end
				end
				default: ;
			endcase
			r.done = done;
			pending_actions.push_back(r);
		endfunction

		function void check_result(poll_result_t got);
			poll_result_t want;
			if (pending_actions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected result: act=%0d bus=%0d servo=%h slot=%h val=%h done=%b",
						$realtime, got.action, got.bus, got.servo, got.slot, got.value, got.done);
				return;
			end
			want = pending_actions.pop_front();
			if (got.action !== want.action || got.bus !== want.bus ||
			    got.servo !== want.servo || got.slot !== want.slot ||
			    got.value !== want.value || got.done !== want.done) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t mismatch expected: act=%0d bus=%0d servo=%h slot=%h val=%h done=%b",
						$realtime, want.action, want.bus, want.servo, want.slot, want.value,
						want.done);
					$display("%0t          actual:   act=%0d bus=%0d servo=%h slot=%h val=%h done=%b",
						$realtime, got.action, got.bus, got.servo, got.slot, got.value,
						got.done);
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	mbps_in_if  item_ch ();
	mbps_out_if result_ch ();

	poll_scoreboard sb;
	int  items_sent;
	int  idle_cycles;
	bit  calm;
	bit  hold_req;

	multi_bus_poll_sequencer_core #(
		.BUS_COUNT      (BUSES),
		.MOTORS_PER_BUS (DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	always #6 clk = ~clk;

	function automatic item_t rand_item();
		item_t it;
		it.operation      = 2'($urandom_range(0, 3));
		it.motor_index    = 8'($urandom_range(0, 255));
		it.bus_number     = 8'($urandom_range(0, 255));
		it.servo_id       = 8'($urandom_range(0, 255));
		it.bus_slot       = 3'($urandom_range(0, 7));
		it.reply_ready    = 1'($urandom_range(0, 1));
		it.reply_position = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic item_t mk_begin();
		item_t it;
		it = rand_item();
		it.operation = OP_BEGIN;
		return it;
	endfunction

	function automatic item_t mk_add(logic [7:0] motor, logic [7:0] busnum, logic [7:0] servo);
		item_t it;
		it = rand_item();
		it.operation   = OP_ADD;
		it.motor_index = motor;
		it.bus_number  = busnum;
		it.servo_id    = servo;
		return it;
	endfunction

	function automatic item_t mk_visit(logic [2:0] slot, logic ready, logic [15:0] pos);
		item_t it;
		it = rand_item();
		it.operation      = OP_VISIT;
		it.bus_slot       = slot;
		it.reply_ready    = ready;
		it.reply_position = pos;
		return it;
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_item(item_t it);
		if (!calm && $urandom_range(0, 99) < 14) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.operation      <= it.operation;
		item_ch.motor_index    <= it.motor_index;
		item_ch.bus_number     <= it.bus_number;
		item_ch.servo_id       <= it.servo_id;
		item_ch.bus_slot       <= it.bus_slot;
		item_ch.reply_ready    <= it.reply_ready;
		item_ch.reply_position <= it.reply_position;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sb.note_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_mask(logic [7:0] mask);
		cfg_we    <= 1'b1;
		cfg_wdata <= mask;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.write_enable(mask);
		@(negedge clk);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : sink_side
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	always @(posedge clk) begin
		poll_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.action = act_t'(result_ch.action);
			got.bus    = result_ch.action_bus;
			got.servo  = result_ch.request_servo;
			got.slot   = result_ch.result_slot;
			got.value  = result_ch.result_value;
			got.done   = result_ch.collection_done;
			sb.check_result(got);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int          ph;
		int          nadd;
		int          favored;
		logic [7:0]  mask;
		logic [7:0]  busnum;
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		item_ch.valid          = 1'b0;
		item_ch.operation      = '0;
		item_ch.motor_index    = '0;
		item_ch.bus_number     = '0;
		item_ch.servo_id       = '0;
		item_ch.bus_slot       = '0;
		item_ch.reply_ready    = 1'b0;
		item_ch.reply_position = '0;
		result_ch.ready        = 1'b0;
		items_sent             = 0;
		idle_cycles            = 0;
		calm                   = 1'b0;
		hold_req               = 1'b0;
		sb = new();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: buses 1 and 8 enabled
		write_mask(8'h81);
		send_item(mk_begin());
		send_item(mk_add(8'h00, 8'd0, 8'h00));     // bus number zero
		send_item(mk_add(8'hFF, 8'd9, 8'hFF));     // just past the last bus
		send_item(mk_add(8'h12, 8'd255, 8'h34));   // far out of range
		send_item(mk_add(8'h20, 8'd2, 8'h77));     // bus not enabled
		for (int i = 0; i < DEPTH; i++)
			send_item(mk_add(i == 0 ? 8'hFF : 8'(i), 8'd1, i == 0 ? 8'hFF : 8'(i * 31)));
		send_item(mk_add(8'h40, 8'd1, 8'h41));     // queue full
		send_item(mk_add(8'hAA, 8'd8, 8'h55));
		send_item(mk_visit(3'd0, 1'b1, 16'h1234)); // idle bus sends even with a reply flagged
		send_item(mk_visit(3'd7, 1'b0, 16'h0000));
		begin
			item_t odd;
			odd = '1;
			send_item(odd);                        // unknown operation
		end
		send_item(mk_visit(3'd0, 1'b0, 16'h5555)); // waiting, no reply
		send_item(mk_visit(3'd0, 1'b1, 16'hFFFF));
		send_item(mk_visit(3'd7, 1'b1, 16'h0000));
		send_item(mk_visit(3'd7, 1'b0, 16'hAAAA)); // bus 8 finished
		send_item(mk_begin());
		send_item(mk_visit(3'd7, 1'b0, 16'h0000)); // no active bus: done at once
		send_item(mk_visit(3'd0, 1'b1, 16'h7777)); // visit after done
		send_item(mk_add(8'h99, 8'd1, 8'h98));     // late add keeps done
		wait_drained();

		ph = 0;
		while (items_sent < ITEM_GOAL) begin
			wait_drained();
			if (ph == 0)
				mask = 8'hFF;
			else if (ph == 1)
				mask = 8'h00;
			else if ($urandom_range(0, 4) == 0)
				mask = 8'hFF;
			else
				mask = 8'($urandom_range(0, 255));
			write_mask(mask);
			calm = (ph == 4 || ph == 5);
			if (ph == 2)
				hold_req = 1'b1;

			send_item(mk_begin());
			nadd = $urandom_range(0, 11);
			favored = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
			for (int i = 0; i < nadd; i++) begin
				if ($urandom_range(0, 9) == 0)
					busnum = 8'($urandom_range(0, 255));
				else if (favored != 0)
					busnum = 8'(favored);
				else
					busnum = 8'($urandom_range(1, 8));
				send_item(mk_add(8'($urandom_range(0, 255)), busnum,
					8'($urandom_range(0, 255))));
			end

			for (int t = 0; t < 40 && !sb.done && items_sent < ITEM_GOAL; t++) begin
				for (int s = 0; s < BUSES; s++) begin
					if ($urandom_range(0, 99) < 4)
						send_item(rand_item());
					else if ($urandom_range(0, 99) < 3)
						send_item(mk_add(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)),
							8'($urandom_range(0, 255))));
					if ($urandom_range(0, 99) >= 4)
						send_item(mk_visit(3'(s), $urandom_range(0, 99) < 60,
							($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535))));
				end
			end

			if ($urandom_range(0, 1) == 1) begin
				send_item(mk_visit(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
					16'($urandom_range(0, 65535))));
				send_item(mk_add(8'($urandom_range(0, 255)), 8'($urandom_range(0, 9)),
					8'($urandom_range(0, 255))));
			end
			ph++;
		end

		item_ch.valid <= 1'b0;
		calm = 1'b0;
		@(negedge clk);
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
